@@ sv/pse_pkg.sv @@
// pse_pkg: shared types and constants for the postfix stack evaluator.
// Used by pse_div and postfix_stack_evaluator; depends on nothing.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // token modes
    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_ADD  = 3'd1;
    localparam logic [2:0] MODE_SUB  = 3'd2;
    localparam logic [2:0] MODE_MUL  = 3'd3;
    localparam logic [2:0] MODE_DIV  = 3'd4;
    localparam logic [2:0] MODE_REM  = 3'd5;

    // status / error codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_LEFTOVER = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [30:0] operand;
        logic        last_token;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic              want_rem;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
    } t_div_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ sv/pse_div.sv @@
// pse_div: iterative signed divider, one quotient bit per cycle.
// Truncates toward zero; remainder takes the dividend's sign. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_div_req i_req,
    output pse_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [pse_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [pse_pkg::DATA_W-1:0]      r_quot;
    logic [pse_pkg::DATA_W-1:0]      r_rem;
    logic [pse_pkg::DATA_W-1:0]      r_div;
    logic                            r_neg_q;
    logic                            r_neg_r;
    logic                            r_want_rem;

    logic [pse_pkg::DATA_W-1:0]      w_mag_a;
    logic [pse_pkg::DATA_W-1:0]      w_mag_b;
    logic [pse_pkg::DATA_W:0]        w_shift;
    logic [pse_pkg::DATA_W:0]        w_trial;

    assign w_mag_a = i_req.left[pse_pkg::DATA_W-1]  ? (0 - i_req.left)  : i_req.left;
    assign w_mag_b = i_req.right[pse_pkg::DATA_W-1] ? (0 - i_req.right) : i_req.right;

    // shift in next dividend bit, then try subtracting the divisor
    assign w_shift = {r_rem, r_quot[pse_pkg::DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pse_pkg::DIV_CNT_W'(pse_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot     <= w_mag_a;
            r_rem      <= '0;
            r_div      <= w_mag_b;
            r_neg_q    <= i_req.left[pse_pkg::DATA_W-1] ^ i_req.right[pse_pkg::DATA_W-1];
            r_neg_r    <= i_req.left[pse_pkg::DATA_W-1];
            r_want_rem <= i_req.want_rem;
        end else if (r_busy) begin
            if (!w_trial[pse_pkg::DATA_W]) begin
                r_rem  <= w_trial[pse_pkg::DATA_W-1:0];
                r_quot <= {r_quot[pse_pkg::DATA_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[pse_pkg::DATA_W-1:0];
                r_quot <= {r_quot[pse_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_want_rem) begin
            o_rsp.value = r_neg_r ? (0 - r_rem) : r_rem;
        end else begin
            o_rsp.value = r_neg_q ? (0 - r_quot) : r_quot;
        end
    end

endmodule

@@ sv/postfix_stack_evaluator.sv @@
// postfix_stack_evaluator: reverse Polish integer evaluator, top level.
// Depends on pse_pkg and pse_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one token per
//   transfer: push an operand, or apply add, sub, mul, div or rem to the two
//   topmost values. The token flagged last_token produces one transfer on the
//   output channel (o_out_valid / i_out_stall / o_out_data) with the final
//   value and a status; other tokens produce nothing.
//   Values live in a 64-entry synchronous RAM; the top of stack is held in a
//   register, so an operator needs a single RAM read (the left operand).
//   Per token: a push or ignored token completes in the idle state; add,
//   sub and mul go through RAM read, execute and retire; div and rem also
//   wait in a divide state on the bit-serial divider, one quotient bit per cycle.
//   The result sits in an output register. A new token is taken while that
//   register drains; while it is full and stalled, input stalls too, and an
//   operator finishing with last_token waits in the retire state.
//   Reset (synchronous, active low) empties the stack and clears the error;
//   RAM contents are not cleared, since only entries below the count are read.
//   After a last token the stack and error are cleared for the next expression.
//   The first error of an expression freezes the stack until its last token.

module postfix_stack_evaluator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pse_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pse_pkg::t_out_item o_out_data
);

    // stack RAM, one write and one read port, registered read data
    logic [pse_pkg::DATA_W-1:0] r_stack_mem [pse_pkg::STACK_DEPTH];
    logic [pse_pkg::DATA_W-1:0] r_rdata;
    logic                       w_mem_we;
    logic [pse_pkg::ADDR_W-1:0] w_waddr;
    logic [pse_pkg::DATA_W-1:0] w_wdata;
    logic [pse_pkg::ADDR_W-1:0] w_raddr;

    pse_pkg::t_state            r_state, n_state;
    logic [pse_pkg::CNT_W-1:0]  r_count, n_count;
    logic [2:0]                 r_err, n_err;
    logic [pse_pkg::DATA_W-1:0] r_tos, n_tos;
    logic [2:0]                 r_mode, n_mode;
    logic                       r_last, n_last;
    logic                       r_out_valid, n_out_valid;
    pse_pkg::t_out_item         r_out_data, n_out_data;

    logic [pse_pkg::ADDR_W-1:0] w_idx_top;
    logic [pse_pkg::ADDR_W-1:0] w_idx_left;
    logic                       w_in_xfer;
    logic                       w_out_free;
    logic [pse_pkg::DATA_W-1:0] w_product;

    pse_pkg::t_div_req          w_div_req;
    pse_pkg::t_div_rsp          w_div_rsp;

    // final value and status from the end-of-expression state
    function automatic pse_pkg::t_out_item finalize(
        input logic [2:0]                 err,
        input logic [pse_pkg::CNT_W-1:0]  count,
        input logic [pse_pkg::DATA_W-1:0] tos
    );
        pse_pkg::t_out_item res;
        res.status       = err;
        res.result_value = '0;
        if (err == pse_pkg::ST_OK) begin
            if (count == '0) begin
                res.status = pse_pkg::ST_MISSING;
            end else if (count > pse_pkg::CNT_W'(1)) begin
                res.status = pse_pkg::ST_LEFTOVER;
            end else begin
                res.result_value = tos;
            end
        end
        return res;
    endfunction

    assign w_idx_top  = pse_pkg::ADDR_W'(r_count - pse_pkg::CNT_W'(1));
    assign w_idx_left = pse_pkg::ADDR_W'(r_count - pse_pkg::CNT_W'(2));

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pse_pkg::S_IDLE) || !w_out_free;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // low 32 bits of the product; wraps like the two's complement multiply
    assign w_product = r_rdata * r_tos;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_stack_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_stack_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pse_pkg::S_IDLE;
            r_count     <= '0;
            r_err       <= pse_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos      <= n_tos;
        r_mode     <= n_mode;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    always_comb begin
        logic                       v_exec;
        logic [pse_pkg::CNT_W-1:0]  v_count;
        logic [2:0]                 v_err;
        logic [pse_pkg::DATA_W-1:0] v_tos;

        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_tos       = r_tos;
        n_mode      = r_mode;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        w_mem_we    = 1'b0;
        w_waddr     = w_idx_top;
        w_wdata     = r_tos;
        w_raddr     = w_idx_left;

        w_div_req.start    = 1'b0;
        w_div_req.want_rem = (r_mode == pse_pkg::MODE_REM);
        w_div_req.left     = r_rdata;
        w_div_req.right    = r_tos;

        v_exec  = 1'b0;
        v_count = r_count;
        v_err   = r_err;
        v_tos   = r_tos;

        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    if (r_err == pse_pkg::ST_OK) begin
                        case (i_in_data.mode)
                            pse_pkg::MODE_PUSH: begin
                                if (r_count >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                                    v_err = pse_pkg::ST_OVERFLOW;
                                end else begin
                                    // spill old top into RAM, operand becomes top
                                    w_mem_we = (r_count != '0);
                                    v_count  = r_count + 1'b1;
                                    v_tos    = {1'b0, i_in_data.operand};
                                end
                            end
                            pse_pkg::MODE_ADD, pse_pkg::MODE_SUB, pse_pkg::MODE_MUL,
                            pse_pkg::MODE_DIV, pse_pkg::MODE_REM: begin
                                if (r_count < pse_pkg::CNT_W'(2)) begin
                                    v_err = pse_pkg::ST_MISSING;
                                end else if ((i_in_data.mode == pse_pkg::MODE_DIV ||
                                              i_in_data.mode == pse_pkg::MODE_REM) &&
                                             r_tos == '0) begin
                                    v_err = pse_pkg::ST_DIVZERO;
                                end else begin
                                    // left operand read issued now, used in S_EXEC
                                    v_exec = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (v_exec) begin
                        n_mode  = i_in_data.mode;
                        n_last  = i_in_data.last_token;
                        n_state = pse_pkg::S_EXEC;
                    end else if (i_in_data.last_token) begin
                        n_out_valid = 1'b1;
                        n_out_data  = finalize(v_err, v_count, v_tos);
                        n_count     = '0;
                        n_err       = pse_pkg::ST_OK;
                    end else begin
                        n_count = v_count;
                        n_err   = v_err;
                        n_tos   = v_tos;
                    end
                end
            end
            pse_pkg::S_EXEC: begin
                case (r_mode)
                    pse_pkg::MODE_ADD: begin
                        n_tos   = r_rdata + r_tos;
                        n_count = r_count - 1'b1;
                        n_state = pse_pkg::S_DONE;
                    end
                    pse_pkg::MODE_SUB: begin
                        n_tos   = r_rdata - r_tos;
                        n_count = r_count - 1'b1;
                        n_state = pse_pkg::S_DONE;
                    end
                    pse_pkg::MODE_MUL: begin
                        n_tos   = w_product;
                        n_count = r_count - 1'b1;
                        n_state = pse_pkg::S_DONE;
                    end
                    default: begin
                        w_div_req.start = 1'b1;
                        n_state         = pse_pkg::S_DIV;
                    end
                endcase
            end
            pse_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_tos   = w_div_rsp.value;
                    n_count = r_count - 1'b1;
                    n_state = pse_pkg::S_DONE;
                end
            end
            pse_pkg::S_DONE: begin
                if (!r_last) begin
                    n_state = pse_pkg::S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = finalize(r_err, r_count, r_tos);
                    n_count     = '0;
                    n_err       = pse_pkg::ST_OK;
                    n_state     = pse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pse_pkg::S_IDLE;
            end
        endcase
    end

endmodule
